// ===== sv/tfmq_pkg.sv =====
// Shared types and constants for the thermal frame min/max quantizer.
`default_nettype none

package tfmq_pkg;

  localparam int unsigned TEMP_W   = 12;
  localparam int unsigned DIFF_W   = TEMP_W + 1;
  localparam int unsigned MAG_W    = 11;
  localparam int unsigned GRAY_W   = 4;
  localparam int unsigned INDEX_W  = 6;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned SIGN_BIT = 3;

  typedef logic signed [TEMP_W-1:0] temp_t;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_READ,
    ST_START,
    ST_CALC
  } calc_state_e;

  // Level unit status back to the sequencer.
  typedef struct packed {
    logic              done;
    logic [GRAY_W-1:0] level;
  } lvl_res_t;

endpackage

`default_nettype wire

// ===== sv/tfmq_level_unit.sv =====
// Iterative gray level unit: one threshold compare per cycle.
`default_nettype none

module tfmq_level_unit
  import tfmq_pkg::*;
#(
  parameter int unsigned LEVEL_COUNT = 9
) (
  input  wire   clk_i,
  input  wire   rst_ni,
  input  wire   start_i,
  input  temp_t temp_i,
  input  temp_t min_i,
  input  temp_t max_i,
  output lvl_res_t res_o
);

  localparam int unsigned KW     = $clog2(LEVEL_COUNT);
  localparam int unsigned PROD_W = DIFF_W + $clog2(LEVEL_COUNT);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [KW-1:0]     k_q, k_d;
  logic [PROD_W-1:0] lhs_q, lhs_d;
  logic [PROD_W-1:0] acc_q, acc_d;
  logic [PROD_W-1:0] span_q, span_d;
  logic [GRAY_W-1:0] lvl_q, lvl_d;
  logic [DIFF_W-1:0] diff;
  logic [DIFF_W-1:0] span;
  logic              last_k;

  assign diff   = DIFF_W'(signed'({temp_i[TEMP_W-1], temp_i}) - signed'({min_i[TEMP_W-1], min_i}));
  assign span   = DIFF_W'(signed'({max_i[TEMP_W-1], max_i}) - signed'({min_i[TEMP_W-1], min_i}));
  assign last_k = (k_q == KW'(LEVEL_COUNT - 2));

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    k_d    = k_q;
    lhs_d  = lhs_q;
    acc_d  = acc_q;
    span_d = span_q;
    lvl_d  = lvl_q;
    if (start_i) begin
      busy_d = 1'b1;
      k_d    = '0;
      acc_d  = '0;
      lvl_d  = '0;
      lhs_d  = PROD_W'(LEVEL_COUNT) * PROD_W'(diff);
      span_d = PROD_W'(span);
    end else if (busy_q) begin
      // threshold k sits at k*span; acc walks it up one span a cycle
      if (lhs_q > acc_q) begin
        lvl_d = lvl_q + GRAY_W'(1);
      end
      acc_d = acc_q + span_q;
      k_d   = k_q + KW'(1);
      if (last_k) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      k_q    <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      k_q    <= k_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lhs_q  <= lhs_d;
    acc_q  <= acc_d;
    span_q <= span_d;
    lvl_q  <= lvl_d;
  end

  assign res_o.done  = done_q;
  assign res_o.level = lvl_q;

endmodule

`default_nettype wire

// ===== sv/thermal_frame_minmax_quantizer.sv =====
// Top level of the thermal frame min/max quantizer: loader, pixel store, emit sequencer.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+------------------------------------------
//  in      | to block  | in_valid_i / in_stall_o  | temp_low_byte_i, temp_high_byte_i
//  out     | from block| out_valid_o / out_stall_i| pixel_index_o, gray_level_o, pixel_temp_o,
//          |           |                        | frame_min_o, frame_max_o, last_of_frame_o
//
// Loading accepts one input beat per cycle while not stalled; the store write and min/max update
// happen on accept. After the last pixel of a frame, each result goes through a store read, a start
// step, one pass per threshold through the single threshold compare unit, a step to latch the level,
// and the beat on the output, held while out_stall_i is high.
// Input is stalled for the whole emit phase.
// Reset clears the sequencer, pixel count and min/max; the pixel store needs no reset.
`default_nettype none

module thermal_frame_minmax_quantizer
  import tfmq_pkg::*;
#(
  parameter int unsigned FRAME_PIXELS = 64,
  parameter int unsigned LEVEL_COUNT  = 9
) (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                in_valid_i,
  output logic               in_stall_o,
  input  wire  [BYTE_W-1:0]  temp_low_byte_i,
  input  wire  [BYTE_W-1:0]  temp_high_byte_i,
  output logic               out_valid_o,
  input  wire                out_stall_i,
  output logic [INDEX_W-1:0] pixel_index_o,
  output logic [GRAY_W-1:0]  gray_level_o,
  output temp_t              pixel_temp_o,
  output temp_t              frame_min_o,
  output temp_t              frame_max_o,
  output logic               last_of_frame_o
);

  localparam int unsigned IDX_W = (FRAME_PIXELS > 1) ? $clog2(FRAME_PIXELS) : 1;

  calc_state_e       state_q, state_d;
  logic [IDX_W-1:0]  cnt_q, cnt_d;
  logic [IDX_W-1:0]  rd_idx_q, rd_idx_d;
  temp_t             min_q, min_d;
  temp_t             max_q, max_d;
  logic              out_valid_q, out_valid_d;
  logic [GRAY_W-1:0] gray_q;
  temp_t             out_temp_q;
  temp_t             rd_data_q;
  temp_t             mem [FRAME_PIXELS];

  logic              in_acc;
  logic              out_acc;
  logic              lvl_start;
  lvl_res_t          lvl_res;
  logic [MAG_W-1:0]  mag;
  temp_t             temp_dec;
  logic              last_in;
  logic              last_rd;

  assign mag      = {temp_high_byte_i[MAG_W-BYTE_W-1:0], temp_low_byte_i};
  assign temp_dec = temp_high_byte_i[SIGN_BIT] ? temp_t'(-signed'({1'b0, mag}))
                                               : temp_t'({1'b0, mag});

  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_acc = out_valid_o && !out_stall_i;
  assign last_in = (cnt_q == IDX_W'(FRAME_PIXELS - 1));
  assign last_rd = (rd_idx_q == IDX_W'(FRAME_PIXELS - 1));

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_LOAD:  if (in_acc && last_in) state_d = ST_READ;
      ST_READ:  state_d = ST_START;
      ST_START: state_d = ST_CALC;
      ST_CALC: begin
        if (out_acc) begin
          state_d = last_rd ? ST_LOAD : ST_READ;
        end
      end
      default:  state_d = ST_LOAD;
    endcase
  end

  // outputs and datapath control
  always_comb begin
    in_stall_o  = (state_q != ST_LOAD);
    lvl_start   = (state_q == ST_START);
    cnt_d       = cnt_q;
    rd_idx_d    = rd_idx_q;
    min_d       = min_q;
    max_d       = max_q;
    out_valid_d = out_valid_q;
    if (in_acc) begin
      cnt_d = last_in ? '0 : cnt_q + IDX_W'(1);
      if (cnt_q == '0) begin
        min_d = temp_dec;
        max_d = temp_dec;
      end else begin
        if (temp_dec > max_q) max_d = temp_dec;
        if (temp_dec < min_q) min_d = temp_dec;
      end
      if (last_in) rd_idx_d = '0;
    end
    if (lvl_res.done) begin
      out_valid_d = 1'b1;
    end
    if (out_acc) begin
      out_valid_d = 1'b0;
      // advance to the next stored pixel
      rd_idx_d    = last_rd ? '0 : rd_idx_q + IDX_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_LOAD;
      cnt_q       <= '0;
      rd_idx_q    <= '0;
      min_q       <= '0;
      max_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      rd_idx_q    <= rd_idx_d;
      min_q       <= min_d;
      max_q       <= max_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      mem[cnt_q] <= temp_dec;
    end
    rd_data_q <= mem[rd_idx_q];
  end

  // hold the result beat until taken
  always_ff @(posedge clk_i) begin
    if (lvl_start) begin
      out_temp_q <= rd_data_q;
    end
    if (lvl_res.done) begin
      gray_q <= lvl_res.level;
    end
  end

  tfmq_level_unit #(
    .LEVEL_COUNT(LEVEL_COUNT)
  ) u_level (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(lvl_start),
    .temp_i (rd_data_q),
    .min_i  (min_q),
    .max_i  (max_q),
    .res_o  (lvl_res)
  );

  assign out_valid_o     = out_valid_q;
  assign pixel_index_o   = INDEX_W'(rd_idx_q);
  assign gray_level_o    = gray_q;
  assign pixel_temp_o    = out_temp_q;
  assign frame_min_o     = min_q;
  assign frame_max_o     = max_q;
  assign last_of_frame_o = last_rd;

  a_gray_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (gray_level_o <= GRAY_W'(LEVEL_COUNT - 1)))
    else $error("gray level above top level");

  a_min_le_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (frame_min_o <= frame_max_o))
    else $error("frame min above frame max");

  a_flat_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (frame_min_o == frame_max_o)) |-> (gray_level_o == '0))
    else $error("flat frame gave nonzero level");

  a_hottest_top: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (frame_min_o != frame_max_o) && (pixel_temp_o == frame_max_o))
      |-> (gray_level_o == GRAY_W'(LEVEL_COUNT - 1)))
    else $error("hottest pixel not at top level");

endmodule

`default_nettype wire

// ===== sim/gray_level_checker.sv =====
// Checker for the thermal frame quantizer: tracks each frame, predicts the gray-level beats and compares them.
module gray_level_checker
  import tfmq_pkg::*;
#(
  parameter int unsigned FRAME_PIXELS = 64,
  parameter int unsigned LEVEL_COUNT  = 9
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  logic [BYTE_W-1:0]  temp_low_byte_i,
  input  logic [BYTE_W-1:0]  temp_high_byte_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  logic [INDEX_W-1:0] pixel_index_i,
  input  logic [GRAY_W-1:0]  gray_level_i,
  input  temp_t              pixel_temp_i,
  input  temp_t              frame_min_i,
  input  temp_t              frame_max_i,
  input  logic               last_of_frame_i,
  output int                 errors_o,
  output int                 pending_o,
  output int                 beats_o
);

  localparam int LEVELS    = LEVEL_COUNT;
  localparam int MAX_NOTES = 200;

  typedef struct {
    logic [INDEX_W-1:0] index;
    logic [GRAY_W-1:0]  level;
    temp_t              temp;
    temp_t              lo;
    temp_t              hi;
    logic               last;
  } gray_beat_t;

  temp_t       frame_pixels [FRAME_PIXELS];
  temp_t       coldest;
  temp_t       hottest;
  int unsigned pixels_seen;
  gray_beat_t  expected_levels [$];

  // Sign-magnitude, quarter-degree steps; the top nibble of the high byte is don't-care.
  function automatic temp_t decode_temp(logic [BYTE_W-1:0] lo_byte, logic [BYTE_W-1:0] hi_byte);
    int mag;
    mag = int'({hi_byte[MAG_W-BYTE_W-1:0], lo_byte});
    return temp_t'(hi_byte[SIGN_BIT] ? -mag : mag);
  endfunction

  function automatic logic [GRAY_W-1:0] gray_for(temp_t t, temp_t lo, temp_t hi);
    int span;
    int scaled;
    int level;
    span   = int'(hi) - int'(lo);
    scaled = LEVELS * (int'(t) - int'(lo));
    level  = 0;
    for (int k = 0; k <= LEVELS - 2; k++) begin
      if (scaled > k * span) level++;
    end
    return GRAY_W'(level);
  endfunction

  task automatic absorb_pixel(temp_t t);
    frame_pixels[pixels_seen] = t;
    if (pixels_seen == 0) begin
      coldest = t;
      hottest = t;
    end else begin
      if (t > hottest) hottest = t;
      if (t < coldest) coldest = t;
    end
    pixels_seen++;
    if (pixels_seen == FRAME_PIXELS) begin
      for (int i = 0; i < FRAME_PIXELS; i++) begin
        expected_levels.push_back('{
          index: INDEX_W'(i),
          level: gray_for(frame_pixels[i], coldest, hottest),
          temp:  frame_pixels[i],
          lo:    coldest,
          hi:    hottest,
          last:  (i == FRAME_PIXELS - 1)
        });
      end
      pixels_seen = 0;
    end
  endtask

  task automatic compare_field(string field, logic signed [31:0] want, logic signed [31:0] got);
    if (got !== want) begin
      errors_o++;
      // limit log volume on a badly broken design
      if (errors_o <= MAX_NOTES)
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    gray_beat_t want;
    if (!rst_ni) begin
      pixels_seen = 0;
      coldest     = '0;
      hottest     = '0;
      errors_o    = 0;
      beats_o     = 0;
      expected_levels.delete();
      pending_o <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        beats_o++;
        if (expected_levels.size() == 0) begin
          errors_o++;
          $display("%0t: unexpected gray-level beat, expected none, got pixel %0d level %0d",
                   $time, pixel_index_i, gray_level_i);
        end else begin
          want = expected_levels.pop_front();
          compare_field("pixel_index",   32'(want.index), 32'(pixel_index_i));
          compare_field("gray_level",    32'(want.level), 32'(gray_level_i));
          compare_field("pixel_temp",    32'(want.temp),  32'(pixel_temp_i));
          compare_field("frame_min",     32'(want.lo),    32'(frame_min_i));
          compare_field("frame_max",     32'(want.hi),    32'(frame_max_i));
          compare_field("last_of_frame", 32'(want.last),  32'(last_of_frame_i));
        end
      end
      if (in_valid_i && !in_stall_i)
        absorb_pixel(decode_temp(temp_low_byte_i, temp_high_byte_i));
      pending_o <= expected_levels.size();
    end
  end

endmodule

// ===== sim/tb_top.sv =====
// Testbench top for the thermal frame quantizer: clock, reset, pixel stimulus, flow control, verdict.
module tb_top;
  import tfmq_pkg::*;

  localparam int FRAME_PIXELS = 64;
  localparam int LEVEL_COUNT  = 9;
  localparam int FRAMES       = 7;
  localparam int LONG_HOLD    = 400;
  localparam int QUIET_LIMIT  = 4000;
  localparam int DRAIN_CYCLES = 30;

  typedef enum {FRAME_WIDE, FRAME_FLAT, FRAME_NARROW, FRAME_EXTREME} frame_kind_e;

  // Byte pairs {high, low} that open the first frame: field extremes, negative zero,
  // ignored high-nibble bits, alternating bit patterns.
  localparam logic [15:0] EDGE_PIXELS [16] = '{
    16'h0064, 16'h07FF, 16'h0FFF, 16'h0800, 16'h0000, 16'hF000, 16'hF7FF, 16'h0001,
    16'h0801, 16'h0100, 16'h0480, 16'h0A55, 16'h05AA, 16'h0C00, 16'h03FF, 16'h8B33
  };

  logic              clk_i     = 1'b0;
  logic              rst_ni    = 1'b0;
  logic              in_valid  = 1'b0;
  logic [BYTE_W-1:0] temp_lo   = '0;
  logic [BYTE_W-1:0] temp_hi   = '0;
  logic              out_stall = 1'b0;

  logic               in_stall;
  logic               out_valid;
  logic [INDEX_W-1:0] pixel_index;
  logic [GRAY_W-1:0]  gray_level;
  temp_t              pixel_temp;
  temp_t              frame_min;
  temp_t              frame_max;
  logic               last_of_frame;

  int errors;
  int pending;
  int beats;
  int pixels_sent = 0;
  int idle_pct    = 0;
  int stall_pct   = 0;
  bit hold_armed  = 1'b0;

  thermal_frame_minmax_quantizer #(
    .FRAME_PIXELS (FRAME_PIXELS),
    .LEVEL_COUNT  (LEVEL_COUNT)
  ) dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .temp_low_byte_i  (temp_lo),
    .temp_high_byte_i (temp_hi),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .pixel_index_o    (pixel_index),
    .gray_level_o     (gray_level),
    .pixel_temp_o     (pixel_temp),
    .frame_min_o      (frame_min),
    .frame_max_o      (frame_max),
    .last_of_frame_o  (last_of_frame)
  );

  gray_level_checker #(
    .FRAME_PIXELS (FRAME_PIXELS),
    .LEVEL_COUNT  (LEVEL_COUNT)
  ) u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid),
    .in_stall_i       (in_stall),
    .temp_low_byte_i  (temp_lo),
    .temp_high_byte_i (temp_hi),
    .out_valid_i      (out_valid),
    .out_stall_i      (out_stall),
    .pixel_index_i    (pixel_index),
    .gray_level_i     (gray_level),
    .pixel_temp_i     (pixel_temp),
    .frame_min_i      (frame_min),
    .frame_max_i      (frame_max),
    .last_of_frame_i  (last_of_frame),
    .errors_o         (errors),
    .pending_o        (pending),
    .beats_o          (beats)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // Pack a temperature as sign-magnitude with random junk in the ignored nibble.
  function automatic logic [15:0] encode_temp(int t, bit neg_zero);
    logic [15:0] raw;
    raw[15:12] = 4'($urandom);
    raw[11]    = (t < 0) || (t == 0 && neg_zero);
    raw[10:0]  = 11'((t < 0) ? -t : t);
    return raw;
  endfunction

  function automatic logic [15:0] pick_pixel(frame_kind_e kind, int base, logic [15:0] flat_raw);
    case (kind)
      FRAME_WIDE:   return 16'($urandom);
      FRAME_FLAT:   return {4'($urandom), flat_raw[11:0]};
      FRAME_NARROW: return encode_temp(base + int'($urandom_range(0, 9)),
                                       1'($urandom_range(0, 1)));
      default: begin
        case ($urandom_range(0, 4))
          0:       return encode_temp(2047, 1'b0);
          1:       return encode_temp(-2047, 1'b0);
          2:       return encode_temp(0, 1'($urandom_range(0, 1)));
          3:       return encode_temp(int'($urandom_range(0, 2)) - 1, 1'b0);
          default: return 16'($urandom);
        endcase
      end
    endcase
  endfunction

  // Offer one pixel beat, with random idle cycles ahead of it, and hold it until accepted.
  task automatic send_pixel(logic [15:0] raw);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    temp_hi  <= raw[15:8];
    temp_lo  <= raw[7:0];
    do @(posedge clk_i); while (in_stall);
    pixels_sent++;
  endtask

  // Receiver: random stalls, plus one long hold-off once a frame starts emitting.
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_armed && out_valid) begin
        hold_armed = 1'b0;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk_i);
      end
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // Watchdog on cycles without any accepted beat.
  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk_i);
      if (!rst_ni || (in_valid && !in_stall) || (out_valid && !out_stall))
        quiet = 0;
      else
        quiet++;
      if (quiet == QUIET_LIMIT) begin
        $display("%0t: no beat accepted for %0d cycles, %0d gray-level beats outstanding",
                 $time, QUIET_LIMIT, pending);
        $display("thermal_frame_minmax_quantizer regression: fail");
        $finish;
      end
    end
  end

  initial begin
    frame_kind_e schedule [FRAMES];
    frame_kind_e kind;
    logic [15:0] raw;
    logic [15:0] flat_raw;
    int          base;
    schedule = '{FRAME_WIDE, FRAME_FLAT, FRAME_NARROW, FRAME_EXTREME,
                 FRAME_FLAT, FRAME_NARROW, FRAME_WIDE};
    schedule[FRAMES-1] = frame_kind_e'($urandom_range(0, 3));

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int f = 0; f < FRAMES; f++) begin
      kind = schedule[f];
      case (f % 4)
        0:       begin idle_pct = 0;  stall_pct = 0;  end
        1:       begin idle_pct = 80; stall_pct = 0;  end
        2:       begin idle_pct = 0;  stall_pct = 80; end
        default: begin idle_pct = 36; stall_pct = 36; end
      endcase
      // next frame's pixels back up behind the long hold-off
      if (f == 2) hold_armed = 1'b1;
      base     = int'($urandom_range(0, 4085)) - 2047;
      flat_raw = encode_temp($urandom_range(0, 1) ? 0 : int'($urandom_range(0, 4094)) - 2047,
                             1'($urandom_range(0, 1)));
      for (int p = 0; p < FRAME_PIXELS; p++) begin
        if (f == 0 && p < 16)
          raw = EDGE_PIXELS[p];
        else
          raw = pick_pixel(kind, base, flat_raw);
        send_pixel(raw);
      end
      // after frame index 4, drain it completely before offering the next one
      if (f == 4) begin
        in_valid <= 1'b0;
        do @(posedge clk_i); while (pending != 0);
      end
    end

    in_valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("covered %0d frames: %0d pixels in, %0d gray-level beats checked",
             FRAMES, pixels_sent, beats);
    $display("wide, flat, narrow and extreme frames under free-run, idle, stall and hold-off");
    if (errors == 0)
      $display("thermal_frame_minmax_quantizer regression: pass");
    else
      $display("thermal_frame_minmax_quantizer regression: fail");
    $finish;
  end

endmodule

// ===== files.f =====
sv/tfmq_pkg.sv
sv/tfmq_level_unit.sv
sv/thermal_frame_minmax_quantizer.sv
sim/gray_level_checker.sv
sim/tb_top.sv
